// ----- hw/rtl/smd_pkg.sv -----
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the signed 32x32 multiply / 64/32 divide
// pipeline: item structs, request codes and the word carried between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

  // Word width of one register and the number of cells (one bit per cell)
  localparam int unsigned W     = 32;
  localparam int unsigned STEPS = W;

  // Request codes
  localparam logic REQ_MUL = 1'b0;
  localparam logic REQ_DIV = 1'b1;

  // Input item
  typedef struct packed {
    logic         req_type;
    logic [W-1:0] even_reg;
    logic [W-1:0] odd_reg;
    logic [W-1:0] operand;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [W-1:0] even_out;
    logic [W-1:0] odd_out;
    logic         divide_exception;
  } out_item_t;

  // Word handed from cell to cell
  typedef struct packed {
    logic         is_div;     // divide, else multiply
    logic         res_neg;    // quotient or product is negative
    logic         rem_neg;    // remainder takes a negative sign
    logic         exc;        // zero divisor or quotient above 32 bits
    logic [W:0]   acc;        // partial remainder / high product word
    logic [W-1:0] low;        // quotient bits / low product word
    logic [W-1:0] opd;        // divisor or multiplicand magnitude
    logic [W-1:0] orig_even;  // pair returned on exception
    logic [W-1:0] orig_odd;
  } lane_t;

endpackage

`default_nettype wire

// ----- hw/rtl/signed_mul_div_64_32_top.sv -----
// ----------------------------------------------------------------------------
// signed_mul_div_64_32_top
// Signed 32x32 -> 64 multiply and signed 64/32 divide on a register pair,
// built as a pipeline of one-bit cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  smd_pkg::in_item_t
//  out_     output     out_valid/ out_stall smd_pkg::out_item_t
//
//  One item per cycle while no result is held (2 entry stages, 32 cells, output).
//  The 32-cell chain sets the latency, one quotient or product bit per cell.
//  Synchronous active-low reset clears all valid bits; payload is not reset.
//  A stalled result holds the whole pipeline, and in_stall is raised then.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_mul_div_64_32_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire smd_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output smd_pkg::out_item_t      out_item
);

  logic                 adv;
  logic                 cv   [smd_pkg::STEPS+1];
  smd_pkg::lane_t       cl   [smd_pkg::STEPS+1];

  // Pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Entry stages
  smd_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (in_valid),
    .item_i  (in_item),
    .valid_o (cv[0]),
    .lane_o  (cl[0])
  );

  // Chain of cells
  for (genvar i = 0; i < smd_pkg::STEPS; i++) begin : g_cell
    smd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (cv[i]),
      .lane_i  (cl[i]),
      .valid_o (cv[i+1]),
      .lane_o  (cl[i+1])
    );
  end

  // Exit stage
  smd_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (cv[smd_pkg::STEPS]),
    .lane_i  (cl[smd_pkg::STEPS]),
    .valid_o (out_valid),
    .item_o  (out_item)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/smd_cell.sv -----
// ----------------------------------------------------------------------------
// smd_cell
// One step of the chain: a restoring divide step (shift left, trial subtract)
// or a shift-add multiply step (conditional add, shift right).
// ----------------------------------------------------------------------------
`default_nettype none

module smd_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          valid_i,
  input  wire smd_pkg::lane_t lane_i,
  output logic               valid_o,
  output smd_pkg::lane_t     lane_o
);

  logic                     valid_r;
  smd_pkg::lane_t           lane_r;
  smd_pkg::lane_t           lane_nxt;
  logic [smd_pkg::W:0]      mul_sum;
  logic [smd_pkg::W:0]      div_sh;
  logic [smd_pkg::W+1:0]    div_diff;

  // Step arithmetic
  always_comb begin
    mul_sum  = {1'b0, lane_i.acc[smd_pkg::W-1:0]}
             + (lane_i.low[0] ? {1'b0, lane_i.opd} : '0);
    div_sh   = {lane_i.acc[smd_pkg::W-1:0], lane_i.low[smd_pkg::W-1]};
    div_diff = {1'b0, div_sh} - {2'b00, lane_i.opd};
    lane_nxt = lane_i;
    if (lane_i.is_div) begin
      // borrow clear: keep the difference and set the quotient bit
      lane_nxt.acc = div_diff[smd_pkg::W+1] ? div_sh : div_diff[smd_pkg::W:0];
      lane_nxt.low = {lane_i.low[smd_pkg::W-2:0], ~div_diff[smd_pkg::W+1]};
    end else begin
      lane_nxt.acc = {1'b0, mul_sum[smd_pkg::W:1]};
      lane_nxt.low = {mul_sum[0], lane_i.low[smd_pkg::W-1:1]};
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lane_o  = lane_r;

endmodule

`default_nettype wire

// ----- hw/rtl/smd_prep.sv -----
// ----------------------------------------------------------------------------
// smd_prep
// Two entry stages: signs and magnitudes first, then the overflow pre-check
// (high dividend word against divisor) and the first word of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_prep (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              valid_i,
  input  wire smd_pkg::in_item_t item_i,
  output logic                   valid_o,
  output smd_pkg::lane_t         lane_o
);

  typedef struct packed {
    logic                       is_div;
    logic                       res_neg;
    logic                       rem_neg;
    logic [2*smd_pkg::W-1:0]    dvd_mag;
    logic [smd_pkg::W-1:0]      op_mag;
    logic [smd_pkg::W-1:0]      od_mag;
    logic [smd_pkg::W-1:0]      orig_even;
    logic [smd_pkg::W-1:0]      orig_odd;
  } mag_t;

  logic                         va_r;
  mag_t                         ma_r;
  mag_t                         ma_nxt;
  logic [2*smd_pkg::W-1:0]      dvd;
  logic                         vb_r;
  smd_pkg::lane_t               lb_r;
  smd_pkg::lane_t               lb_nxt;
  logic [smd_pkg::W-1:0]        hi_mag;

  // Stage A: sign and magnitude of each operand
  always_comb begin
    dvd               = {item_i.even_reg, item_i.odd_reg};
    ma_nxt.is_div     = (item_i.req_type == smd_pkg::REQ_DIV);
    ma_nxt.rem_neg    = item_i.even_reg[smd_pkg::W-1];
    ma_nxt.res_neg    = ma_nxt.is_div
                      ? (item_i.even_reg[smd_pkg::W-1] ^ item_i.operand[smd_pkg::W-1])
                      : (item_i.odd_reg[smd_pkg::W-1] ^ item_i.operand[smd_pkg::W-1]);
    ma_nxt.dvd_mag    = item_i.even_reg[smd_pkg::W-1] ? (~dvd + 1'b1) : dvd;
    ma_nxt.op_mag     = item_i.operand[smd_pkg::W-1]
                      ? (~item_i.operand + 1'b1) : item_i.operand;
    ma_nxt.od_mag     = item_i.odd_reg[smd_pkg::W-1]
                      ? (~item_i.odd_reg + 1'b1) : item_i.odd_reg;
    ma_nxt.orig_even  = item_i.even_reg;
    ma_nxt.orig_odd   = item_i.odd_reg;
  end

  // Stage B: pre-check and chain entry word
  always_comb begin
    hi_mag           = ma_r.dvd_mag[2*smd_pkg::W-1:smd_pkg::W];
    lb_nxt.is_div    = ma_r.is_div;
    lb_nxt.res_neg   = ma_r.res_neg;
    lb_nxt.rem_neg   = ma_r.rem_neg;
    // quotient of 2^32 or more, zero divisor included
    lb_nxt.exc       = ma_r.is_div && (hi_mag >= ma_r.op_mag);
    lb_nxt.acc       = ma_r.is_div ? {1'b0, hi_mag} : '0;
    lb_nxt.low       = ma_r.is_div ? ma_r.dvd_mag[smd_pkg::W-1:0] : ma_r.od_mag;
    lb_nxt.opd       = ma_r.op_mag;
    lb_nxt.orig_even = ma_r.orig_even;
    lb_nxt.orig_odd  = ma_r.orig_odd;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= ma_nxt;
      lb_r <= lb_nxt;
    end
  end

  assign valid_o = vb_r;
  assign lane_o  = lb_r;

endmodule

`default_nettype wire

// ----- hw/rtl/smd_post.sv -----
// ----------------------------------------------------------------------------
// smd_post
// Exit stage and output register: final overflow check, sign fix-up of
// quotient, remainder and product, and the exception path.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_post (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           valid_i,
  input  wire smd_pkg::lane_t lane_i,
  output logic                valid_o,
  output smd_pkg::out_item_t  item_o
);

  logic                       valid_r;
  smd_pkg::out_item_t         item_r;
  smd_pkg::out_item_t         item_nxt;
  logic [smd_pkg::W-1:0]      quo;
  logic [smd_pkg::W-1:0]      rem;
  logic                       q_ovf;
  logic [2*smd_pkg::W-1:0]    prod;
  logic [2*smd_pkg::W-1:0]    prod_s;

  // Result selection
  always_comb begin
    quo    = lane_i.low;
    rem    = lane_i.acc[smd_pkg::W-1:0];
    // -2^31 is fine for a negative quotient, anything above is not
    q_ovf  = quo[smd_pkg::W-1] && (!lane_i.res_neg || (quo[smd_pkg::W-2:0] != '0));
    prod   = {lane_i.acc[smd_pkg::W-1:0], lane_i.low};
    prod_s = lane_i.res_neg ? (~prod + 1'b1) : prod;
    if (lane_i.is_div) begin
      if (lane_i.exc || q_ovf) begin
        item_nxt.even_out         = lane_i.orig_even;
        item_nxt.odd_out          = lane_i.orig_odd;
        item_nxt.divide_exception = 1'b1;
      end else begin
        item_nxt.even_out         = lane_i.rem_neg ? (~rem + 1'b1) : rem;
        item_nxt.odd_out          = lane_i.res_neg ? (~quo + 1'b1) : quo;
        item_nxt.divide_exception = 1'b0;
      end
    end else begin
      item_nxt.even_out         = prod_s[2*smd_pkg::W-1:smd_pkg::W];
      item_nxt.odd_out          = prod_s[smd_pkg::W-1:0];
      item_nxt.divide_exception = 1'b0;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/smd_checker.sv -----
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks on the multiply/divide pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire smd_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire smd_pkg::out_item_t out_item
);

  // Input is only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("held result changed");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Nothing can emerge as reset is released
  a_no_early: assert property (@(posedge clk)
    (!rst_n ##1 rst_n) |-> !out_valid)
    else $error("result before any item could pass");

endmodule

bind signed_mul_div_64_32_top smd_checker u_smd_checker (.*);

`default_nettype wire

// ----- sim/tb_signed_mul_div_64_32_top.sv -----
// ----------------------------------------------------------------------------
// tb_signed_mul_div_64_32_top
// Self-checking bench for the register-pair multiply / divide pipeline.
// A queue of operations (directed corner cases, then random multiplies and
// mostly well-formed divides) feeds a clocked driver. Every accepted item is
// run through a behavioural model of the pair arithmetic. A clocked monitor
// compares each result, in order, against the oldest predicted pair. Both
// sides idle at random, apart from one long stretch without idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_signed_mul_div_64_32_top;

  localparam int IDLE_PCT    = 27;
  localparam int STUCK_LIMIT = 4000;   // cycles with no item moving either way
  localparam int DRAIN_WAIT  = 40;     // pipeline latency plus margin
  localparam int N_RANDOM    = 850;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  smd_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  smd_pkg::out_item_t out_item;

  smd_pkg::in_item_t  ops_to_send[$];
  smd_pkg::out_item_t pairs_due[$];

  int n_taken = 0;
  int n_mul = 0;
  int n_div = 0;
  int n_trapped = 0;
  int n_results = 0;
  int n_errors = 0;
  int stuck_cycles = 0;

  // Long stretch with no idling on either side
  wire calm = (n_taken >= 300) && (n_taken < 480);

  signed_mul_div_64_32_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected register pair for one operation
  function automatic smd_pkg::out_item_t predict_pair(smd_pkg::in_item_t op);
    smd_pkg::out_item_t res;
    logic signed [63:0] prod;
    logic signed [63:0] dividend;
    logic [63:0]        num_mag;
    logic [63:0]        quo;
    logic [63:0]        rem;
    logic [63:0]        bound;
    logic [31:0]        den_mag;
    logic               num_neg;
    logic               den_neg;
    logic               quo_neg;
    res = '0;
    if (op.req_type == smd_pkg::REQ_MUL) begin
      prod = $signed({{32{op.odd_reg[31]}}, op.odd_reg}) *
             $signed({{32{op.operand[31]}}, op.operand});
      res.even_out = prod[63:32];
      res.odd_out  = prod[31:0];
    end else begin
      dividend = {op.even_reg, op.odd_reg};
      num_neg  = op.even_reg[31];
      den_neg  = op.operand[31];
      quo_neg  = num_neg ^ den_neg;
      num_mag  = num_neg ? -dividend : dividend;
      den_mag  = den_neg ? -op.operand : op.operand;
      // -2^31 fits, +2^31 does not
      bound    = quo_neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
      // zero divisor or oversized quotient: pair comes back untouched
      res.even_out         = op.even_reg;
      res.odd_out          = op.odd_reg;
      res.divide_exception = 1'b1;
      if (den_mag != '0) begin
        quo = num_mag / {32'h0, den_mag};
        rem = num_mag % {32'h0, den_mag};
        if (quo <= bound) begin
          if (num_neg) rem = -rem;
          if (quo_neg) quo = -quo;
          res.even_out         = rem[31:0];
          res.odd_out          = quo[31:0];
          res.divide_exception = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic smd_pkg::in_item_t pair_op(logic kind, logic [31:0] ev,
                                                logic [31:0] od, logic [31:0] opd);
    smd_pkg::in_item_t it;
    it.req_type = kind;
    it.even_reg = ev;
    it.odd_reg  = od;
    it.operand  = opd;
    return it;
  endfunction

  // Random word of random magnitude and sign
  function automatic logic [31:0] rand_word();
    int          w;
    logic [31:0] v;
    w = $urandom_range(1, 32);
    v = $urandom >> (32 - w);
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Divide built as quotient * divisor + remainder, so most of them complete
  function automatic smd_pkg::in_item_t sane_divide();
    logic [31:0]        den;
    logic signed [63:0] dv;
    logic signed [63:0] q;
    logic signed [63:0] prod;
    logic signed [63:0] rmag;
    logic signed [63:0] dividend;
    den = rand_word();
    if (den == '0) den = 32'h1;
    dv   = $signed({{32{den[31]}}, den});
    q    = $signed({32'h0, $urandom >> $urandom_range(1, 31)});
    if ($urandom_range(0, 1) == 1) q = -q;
    prod = q * dv;
    rmag = $signed({32'h0, $urandom}) % (dv < 0 ? -dv : dv);
    if (prod < 0 || (prod == 0 && $urandom_range(0, 1) == 1))
      dividend = prod - rmag;
    else
      dividend = prod + rmag;
    return pair_op(smd_pkg::REQ_DIV, dividend[63:32], dividend[31:0], den);
  endfunction

  // Driver: new item once the current one has gone or none is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pairs_due.push_back(predict_pair(in_item));
        n_taken++;
        if (in_item.req_type == smd_pkg::REQ_MUL) n_mul++;
        else n_div++;
      end
      if (!in_valid || !in_stall) begin
        if (ops_to_send.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_item  <= ops_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure, in-order compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        n_results++;
        if (pairs_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result: even %08h odd %08h exc %0b",
                     out_item.even_out, out_item.odd_out, out_item.divide_exception);
        end else begin
          if (pairs_due[0].divide_exception) n_trapped++;
          if (out_item.even_out !== pairs_due[0].even_out ||
              out_item.odd_out !== pairs_due[0].odd_out ||
              out_item.divide_exception !== pairs_due[0].divide_exception) begin
            n_errors++;
            if (n_errors <= 10)
              $display("result %0d: expected even %08h odd %08h exc %0b, got %08h %08h %0b",
                       n_results, pairs_due[0].even_out, pairs_due[0].odd_out,
                       pairs_due[0].divide_exception, out_item.even_out,
                       out_item.odd_out, out_item.divide_exception);
          end
          void'(pairs_due.pop_front());
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout: %0d items still expected", pairs_due.size());
    $display("tb_signed_mul_div_64_32_top: errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int pick;
    // multiply corners
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'h0, 32'h8000_0000, 32'h8000_0000));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'h0, 32'hffff_ffff, 32'h8000_0000));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'h5a5a_5a5a, 32'h0, 32'hffff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, 32'ha5a5_a5a5, 32'h1234_5678,
                                  32'hfedc_ba98));
    // zero divisor
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h89ab_cdef, 32'h0123_4567, 32'h0));
    // quotient +2^31 traps, -2^31 does not
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h0, 32'h8000_0000, 32'h1));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h1));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h0, 32'h8000_0000, 32'hffff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h8000_0000, 32'h0, 32'hffff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h7fff_ffff, 32'hffff_ffff, 32'h1));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h4000_0000, 32'h0, 32'h8000_0000));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'hc000_0000, 32'h0, 32'h8000_0000));
    // signs of quotient and remainder, exact division of a negative
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'hffff_ffff, 32'hffff_fffa, 32'h3));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'hffff_ffff, 32'hffff_fff9, 32'h2));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h0, 32'h7, 32'hffff_fffe));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'hffff_ffff, 32'hffff_fff9,
                                  32'hffff_fffe));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h3fff_ffff, 32'hffff_ffff,
                                  32'h7fff_ffff));
    ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, 32'h0, 32'h0, 32'hffff_fffb));

    // random mix: mostly well-formed divides
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: begin
          ops_to_send.push_back(pair_op(smd_pkg::REQ_MUL, $urandom, $urandom, $urandom));
        end
        3, 4, 5, 6: begin
          ops_to_send.push_back(sane_divide());
        end
        7: begin
          // small dividend, sign-extended into the even register
          pick = $urandom;
          ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, {32{pick[31]}}, pick,
                                        rand_word()));
        end
        8: begin
          ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, $urandom, $urandom, $urandom));
        end
        default: begin
          ops_to_send.push_back(pair_op(smd_pkg::REQ_DIV, rand_word(), $urandom,
                                        ($urandom_range(0, 1) == 1) ? 32'h0 : 32'h8000_0000));
        end
      endcase
    end

    // hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_to_send.size() != 0 || in_valid) @(posedge clk);
    while (pairs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d multiplies and %0d divides checked, %0d divides trapped",
             n_mul, n_div, n_trapped);
    $display("%0d results compared, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && pairs_due.size() == 0) begin
      $display("tb_signed_mul_div_64_32_top: clean");
    end else begin
      $display("tb_signed_mul_div_64_32_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/smd_pkg.sv
hw/rtl/smd_cell.sv
hw/rtl/smd_prep.sv
hw/rtl/smd_post.sv
hw/rtl/signed_mul_div_64_32_top.sv
hw/rtl/smd_checker.sv
sim/tb_signed_mul_div_64_32_top.sv
